### design/peak_preserving_decimator_top_assert.svh
// Assertion macros shared by the decimator RTL.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef PEAK_PRESERVING_DECIMATOR_TOP_ASSERT_SVH
`define PEAK_PRESERVING_DECIMATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPD_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define PPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/ppd_pkg.sv
package ppd_pkg;

    localparam int OUT_COUNT_DEFAULT  = 64;
    localparam int MAX_SERIES_DEFAULT = 128;

    localparam int SAMPLE_W = 32;
    localparam int VALUE_W  = 24;
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 8;

    localparam logic [LEN_W-1:0] SERIES_LENGTH_RESET = 8'd128;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [SLOT_W-1:0]          slot_t;
    typedef logic [LEN_W-1:0]           len_t;

endpackage

### design/ppd_if.sv
// Input channel: one raw sample per word.
interface ppd_in_if;
    logic              valid;
    logic              ready;
    ppd_pkg::sample_t  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: one rounded bucket value per word.
interface ppd_out_if;
    logic             valid;
    logic             ready;
    ppd_pkg::value_t  rounded_value;
    ppd_pkg::slot_t   slot;
    logic             last;

    modport source (output valid, output rounded_value, output slot, output last,
                    input ready);
    modport sink   (input valid, input rounded_value, input slot, input last,
                    output ready);
endinterface

// Configuration write channel: series length.
interface ppd_cfg_if;
    logic           valid;
    logic           ready;
    ppd_pkg::len_t  series_length;

    modport source (output valid, output series_length, input ready);
    modport sink   (input valid, input series_length, output ready);
endinterface

### design/peak_preserving_decimator_top.sv
// Channel  Modport  Payload                          Accepted when
// -------  -------  -------------------------------  -------------------------
// cfg      sink     series_length [7:0]              cfg.valid && cfg.ready
// din      sink     sample [31:0] signed Q23.8       din.valid && din.ready
// dout     source   rounded_value [23:0], slot, last dout.valid && dout.ready
//
// All bucket work for a sample is one compare and subtract stage between the
// state registers and the result register.
// A new sample is taken every cycle while the result register is empty or
// is being drained; a held result stalls the input only when dout.ready is low.
// Reset (rst_n low, asynchronous) returns the block to idle with the series
// length register at 128. cfg.ready is always high.
`include "peak_preserving_decimator_top_assert.svh"

module peak_preserving_decimator_top #(
    parameter int OUT_COUNT  = ppd_pkg::OUT_COUNT_DEFAULT,
    parameter int MAX_SERIES = ppd_pkg::MAX_SERIES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ppd_cfg_if.sink   cfg,
    ppd_in_if.sink    din,
    ppd_out_if.source dout
);

    // Bucket boundaries are tracked without division. Bucket i ends at the
    // first position p (samples taken) with (i+1)*L < (p+1)*OUT_COUNT, so two
    // running sums are kept: acc_a = (i+1)*L and acc_b = (p+1)*OUT_COUNT.
    localparam int ACC_W = $clog2(OUT_COUNT * 256 + 1);

    localparam logic [ACC_W-1:0] N_ACC      = ACC_W'(OUT_COUNT);
    localparam logic [ACC_W-1:0] TWO_N_ACC  = ACC_W'(2 * OUT_COUNT);
    localparam ppd_pkg::len_t    LEN_MAX    = ppd_pkg::LEN_W'(MAX_SERIES);
    localparam ppd_pkg::len_t    LEN_MIN    = ppd_pkg::LEN_W'(OUT_COUNT + 1);
    localparam ppd_pkg::slot_t   FINAL_SLOT = ppd_pkg::SLOT_W'(OUT_COUNT - 1);

    // Configuration register.
    ppd_pkg::len_t series_length_reg;

    // Series state.
    logic             active_reg, active_next;
    ppd_pkg::len_t    len_reg, len_next;
    logic [ACC_W-1:0] acc_a_reg, acc_a_next;
    logic [ACC_W-1:0] acc_b_reg, acc_b_next;
    ppd_pkg::slot_t   bidx_reg, bidx_next;
    ppd_pkg::sample_t prev_reg, prev_next;
    ppd_pkg::sample_t best_reg, best_next;
    logic [32:0]      bestd_reg, bestd_next;
    logic             best_valid_reg, best_valid_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    ppd_pkg::value_t  out_value_reg, out_value_next;
    ppd_pkg::slot_t   out_slot_reg, out_slot_next;
    logic             out_last_reg, out_last_next;

    // Per-sample datapath.
    logic             in_fire;
    ppd_pkg::len_t    len_clip, len_eff, len_cur;
    logic [ACC_W-1:0] acc_a_cur, acc_b_cur;
    ppd_pkg::slot_t   bidx_cur;
    ppd_pkg::sample_t prev_cur, best_cur, best_new;
    logic [32:0]      bestd_cur, dist_abs;
    logic             best_valid_cur, take, bucket_done, final_slot;
    logic [33:0]      diff;
    logic [32:0]      mag, mag_round;
    logic [24:0]      quot;
    ppd_pkg::value_t  rounded;

    assign cfg.ready = 1'b1;
    assign din.ready = !out_valid_reg || dout.ready;
    assign in_fire   = din.valid && din.ready;

    assign dout.valid         = out_valid_reg;
    assign dout.rounded_value = out_value_reg;
    assign dout.slot          = out_slot_reg;
    assign dout.last          = out_last_reg;

    // Effective length: limited to MAX_SERIES, then raised to OUT_COUNT+1.
    assign len_clip = (series_length_reg > LEN_MAX) ? LEN_MAX : series_length_reg;
    assign len_eff  = (len_clip < LEN_MIN) ? LEN_MIN : len_clip;

    always_comb
    begin
        // The first sample of a series restarts everything from its own value.
        len_cur        = active_reg ? len_reg : len_eff;
        acc_a_cur      = active_reg ? acc_a_reg : ACC_W'(len_eff);
        acc_b_cur      = active_reg ? (acc_b_reg + N_ACC) : TWO_N_ACC;
        bidx_cur       = active_reg ? bidx_reg : '0;
        prev_cur       = active_reg ? prev_reg : din.sample;
        best_cur       = active_reg ? best_reg : '0;
        bestd_cur      = active_reg ? bestd_reg : '0;
        best_valid_cur = active_reg && best_valid_reg;

        diff     = {{2{din.sample[31]}}, din.sample} - {{2{prev_cur[31]}}, prev_cur};
        dist_abs = diff[33] ? 33'(-diff) : diff[32:0];

        // A tie keeps the earlier sample, so only a strictly larger distance wins.
        take     = !best_valid_cur || (dist_abs > bestd_cur);
        best_new = take ? din.sample : best_cur;

        bucket_done = acc_a_cur < acc_b_cur;
        final_slot  = (bidx_cur == FINAL_SLOT);

        // Round half away from zero on the magnitude; both sides can reach 2^23,
        // but only the positive side needs saturation.
        mag       = best_new[31] ? (33'd0 - {best_new[31], best_new})
                                 : {1'b0, best_new};
        mag_round = mag + 33'd128;
        quot      = mag_round[32:8];
        if (best_new[31])
        begin
            rounded = ppd_pkg::VALUE_W'(25'd0 - quot);
        end
        else if (quot > 25'd8388607)
        begin
            rounded = 24'h7FFFFF;
        end
        else
        begin
            rounded = quot[23:0];
        end
    end

    always_comb
    begin
        active_next     = active_reg;
        len_next        = len_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        bidx_next       = bidx_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        bestd_next      = bestd_reg;
        best_valid_next = best_valid_reg;

        out_valid_next = out_valid_reg && !dout.ready;
        out_value_next = out_value_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;

        if (in_fire)
        begin
            active_next     = 1'b1;
            len_next        = len_cur;
            acc_b_next      = acc_b_cur;
            acc_a_next      = acc_a_cur;
            bidx_next       = bidx_cur;
            prev_next       = prev_cur;
            best_next       = best_new;
            bestd_next      = take ? dist_abs : bestd_cur;
            best_valid_next = 1'b1;

            if (bucket_done)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rounded;
                out_slot_next   = bidx_cur;
                out_last_next   = final_slot;
                prev_next       = best_new;
                best_valid_next = 1'b0;
                acc_a_next      = acc_a_cur + ACC_W'(len_cur);
                bidx_next       = bidx_cur + ppd_pkg::SLOT_W'(1);
                if (final_slot)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_length_reg <= ppd_pkg::SERIES_LENGTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            series_length_reg <= cfg.series_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_a_reg      <= '0;
            acc_b_reg      <= '0;
            bidx_reg       <= '0;
            len_reg        <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
            acc_a_reg      <= acc_a_next;
            acc_b_reg      <= acc_b_next;
            bidx_reg       <= bidx_next;
            len_reg        <= len_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        best_reg      <= best_next;
        bestd_reg     <= bestd_next;
        out_value_reg <= out_value_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    // While a series runs, the current bucket has not yet reached its end.
    `PPD_ASSERT_NOW(a_bucket_open, active_reg, acc_a_reg >= acc_b_reg, "bucket end overrun")

    // The bucket index stays below the slot count.
    `PPD_ASSERT_NOW(a_slot_range, active_reg, {1'b0, bidx_reg} < 7'(OUT_COUNT), "slot overflow")

    // A series never ends on its first sample.
    `PPD_ASSERT_NEXT(a_start, in_fire && !active_reg, active_reg, "series ended on first sample")

    // Emitting the final slot returns the block to idle.
    `PPD_ASSERT_NEXT(a_final_idle, in_fire && bucket_done && final_slot,
        !active_reg && out_last_reg, "final slot did not end series")

endmodule
